@@ hw/rtl/sbc_pkg.sv @@
// Shared types of the segment box clipper.
// No dependencies; imported by every other RTL file but sbc_checker.
`default_nettype none
package sbc_pkg;

    // Per-item control flags that follow the divider pipeline.
    typedef struct packed {
        logic       rej;
        logic [2:0] need_st;
        logic [2:0] need_et;
        logic [2:0] desc;
    } t_side;

endpackage
`default_nettype wire

@@ hw/rtl/sbc_front.sv @@
// Front end: slab bounds, per-axis reject and division operands.
// Depends on sbc_pkg.
`default_nettype none
module sbc_front #(
    parameter int W = 31
) (
    input  logic                 i_clk,
    input  logic [1:0]           i_en,
    input  logic signed [W-1:0]  i_c [3],
    input  logic [W-2:0]         i_r,
    input  logic signed [W-1:0]  i_s [3],
    input  logic signed [W-1:0]  i_e [3],
    output logic signed [W-1:0]  o_s [3],
    output logic [W:0]           o_num_st [3],
    output logic [W:0]           o_num_et [3],
    output logic [W:0]           o_den [3],
    output sbc_pkg::t_side       o_side
);
    import sbc_pkg::*;

    localparam int D = W + 1;

    logic signed [W-1:0] r_s  [3];
    logic signed [W-1:0] r_e  [3];
    logic signed [W:0]   r_hi [3];
    logic signed [W:0]   r_lo [3];

    logic [D-1:0] n_num_st [3];
    logic [D-1:0] n_num_et [3];
    logic [D-1:0] n_den    [3];
    t_side        n_side;
    logic [D-1:0] r_num_st [3];
    logic [D-1:0] r_num_et [3];
    logic [D-1:0] r_den    [3];
    logic signed [W-1:0] r_s2 [3];
    t_side        r_side;

    // Stage A: slab bounds.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int a = 0; a < 3; a++) begin
                r_s[a]  <= i_s[a];
                r_e[a]  <= i_e[a];
                r_hi[a] <= $signed({i_c[a][W-1], i_c[a]}) + $signed({2'b00, i_r});
                r_lo[a] <= $signed({i_c[a][W-1], i_c[a]}) - $signed({2'b00, i_r});
            end
        end
    end

    // Stage B: reject tests and numerators.
    always_comb begin
        logic signed [W+1:0] s2, e2, hi2, lo2;
        logic signed [W+1:0] d_lo_s, d_hi_s, d_s_hi, d_s_lo, d_es, d_se;
        logic rej;
        rej = 1'b0;
        n_side = '0;
        for (int a = 0; a < 3; a++) begin
            s2  = {{2{r_s[a][W-1]}}, r_s[a]};
            e2  = {{2{r_e[a][W-1]}}, r_e[a]};
            hi2 = {r_hi[a][W], r_hi[a]};
            lo2 = {r_lo[a][W], r_lo[a]};
            d_lo_s = lo2 - s2;
            d_hi_s = hi2 - s2;
            d_s_hi = s2 - hi2;
            d_s_lo = s2 - lo2;
            d_es   = e2 - s2;
            d_se   = s2 - e2;
            n_side.desc[a] = (s2 > e2);
            if (s2 < e2) begin
                rej = rej | (s2 > hi2) | (e2 < lo2);
                n_side.need_st[a] = (lo2 > s2);
                n_side.need_et[a] = (e2 > hi2);
                n_num_st[a] = d_lo_s[D-1:0];
                n_num_et[a] = d_hi_s[D-1:0];
                n_den[a]    = d_es[D-1:0];
            end else begin
                rej = rej | (e2 > hi2) | (s2 < lo2);
                n_side.need_st[a] = (hi2 < s2);
                n_side.need_et[a] = (e2 < lo2);
                n_num_st[a] = d_s_hi[D-1:0];
                n_num_et[a] = d_s_lo[D-1:0];
                n_den[a]    = d_se[D-1:0];
            end
            // Feed a harmless operand pair to unused dividers.
            if (!n_side.need_st[a]) n_num_st[a] = '0;
            if (!n_side.need_et[a]) n_num_et[a] = '0;
        end
        n_side.rej = rej;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_num_st <= n_num_st;
            r_num_et <= n_num_et;
            r_den    <= n_den;
            r_s2     <= r_s;
            r_side   <= n_side;
        end
    end

    assign o_s      = r_s2;
    assign o_num_st = r_num_st;
    assign o_num_et = r_num_et;
    assign o_den    = r_den;
    assign o_side   = r_side;

endmodule
`default_nettype wire

@@ hw/rtl/sbc_div.sv @@
// One restoring divider lane, one quotient bit per pipeline stage.
// Depends on sbc_pkg.
`default_nettype none
module sbc_div #(
    parameter int W = 31,
    parameter int F = 16
) (
    input  logic          i_clk,
    input  logic [F:0]    i_en,
    input  logic [W:0]    i_num,
    input  logic [W:0]    i_den,
    output logic [F:0]    o_q
);
    import sbc_pkg::*;

    localparam int D = W + 1;
    localparam int S = F + 1;

    logic [D:0]   r_rem [S];
    logic [D-1:0] r_den [S];
    logic [F:0]   r_q   [S];
    logic [D:0]   n_rem [S];
    logic [F:0]   n_q   [S];

    always_comb begin
        logic [D:0]   rem, diff;
        logic [D-1:0] den;
        logic [F:0]   q;
        logic         ge;
        for (int k = 0; k < S; k++) begin
            if (k == 0) begin
                rem = {1'b0, i_num};
                den = i_den;
                q   = '0;
            end else begin
                rem = r_rem[k-1];
                den = r_den[k-1];
                q   = r_q[k-1];
            end
            ge   = (rem >= {1'b0, den});
            diff = ge ? (rem - {1'b0, den}) : rem;
            n_rem[k] = {diff[D-1:0], 1'b0};
            n_q[k]   = {q[F-1:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < S; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_q = r_q[S-1];

endmodule
`default_nettype wire

@@ hw/rtl/sbc_delay.sv @@
// Delay line that carries side data alongside the divider stages.
// Depends on sbc_pkg.
`default_nettype none
module sbc_delay #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_en,
    input  logic [DW-1:0]    i_data,
    output logic [DW-1:0]    o_data
);
    import sbc_pkg::*;

    logic [DW-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_en[k]) begin
                r_tap[k] <= (k == 0) ? i_data : r_tap[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule
`default_nettype wire

@@ hw/rtl/sbc_back.sv @@
// Back end: entry/exit selection, scaling multiply, rounding and output.
// Depends on sbc_pkg.
`default_nettype none
module sbc_back #(
    parameter int W = 31,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic [2:0]          i_en,
    input  logic [F:0]          i_q_st [3],
    input  logic [F:0]          i_q_et [3],
    input  logic signed [W-1:0] i_s [3],
    input  logic [W:0]          i_d [3],
    input  sbc_pkg::t_side      i_side,
    output logic                o_hit,
    output logic signed [W-1:0] o_a [3],
    output logic signed [W-1:0] o_b [3]
);
    import sbc_pkg::*;

    localparam int D = W + 1;
    localparam int S = F + 1;
    localparam int P = D + S;
    localparam logic [F:0]   T_ONE = {1'b1, {F{1'b0}}};
    localparam logic [P-1:0] HALF  = P'(1) << (F - 1);

    // Stage C
    logic [F:0]          r_tin, r_tout;
    logic                r_hit_c;
    logic signed [W-1:0] r_s_c [3];
    logic [D-1:0]        r_d_c [3];
    logic [2:0]          r_desc_c;
    logic [F:0]          n_tin, n_tout;

    always_comb begin
        logic [F:0] st, et;
        n_tin  = '0;
        n_tout = T_ONE;
        for (int a = 0; a < 3; a++) begin
            st = i_side.need_st[a] ? i_q_st[a] : '0;
            et = i_side.need_et[a] ? i_q_et[a] : T_ONE;
            if (st > n_tin)  n_tin  = st;
            if (et < n_tout) n_tout = et;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_tin    <= n_tin;
            r_tout   <= n_tout;
            r_hit_c  <= !i_side.rej && (n_tout >= n_tin);
            r_s_c    <= i_s;
            r_d_c    <= i_d;
            r_desc_c <= i_side.desc;
        end
    end

    // Stage D: magnitude times t.
    logic [P-1:0]        r_pa [3];
    logic [P-1:0]        r_pb [3];
    logic                r_hit_d;
    logic signed [W-1:0] r_s_d [3];
    logic [2:0]          r_desc_d;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int a = 0; a < 3; a++) begin
                r_pa[a] <= P'(r_d_c[a]) * P'(r_tin);
                r_pb[a] <= P'(r_d_c[a]) * P'(r_tout);
            end
            r_hit_d  <= r_hit_c;
            r_s_d    <= r_s_c;
            r_desc_d <= r_desc_c;
        end
    end

    // Stage E: round to nearest and step from the start point; zero on a miss.
    logic                r_hit;
    logic signed [W-1:0] r_a [3];
    logic signed [W-1:0] r_b [3];
    logic signed [W-1:0] n_a [3];
    logic signed [W-1:0] n_b [3];

    always_comb begin
        logic [P:0]   sa, sb;
        logic [W-1:0] ma, mb;
        for (int a = 0; a < 3; a++) begin
            sa = {1'b0, r_pa[a]} + {1'b0, HALF};
            sb = {1'b0, r_pb[a]} + {1'b0, HALF};
            ma = sa[F +: W];
            mb = sb[F +: W];
            if (!r_hit_d) begin
                n_a[a] = '0;
                n_b[a] = '0;
            end else if (r_desc_d[a]) begin
                n_a[a] = r_s_d[a] - $signed(ma);
                n_b[a] = r_s_d[a] - $signed(mb);
            end else begin
                n_a[a] = r_s_d[a] + $signed(ma);
                n_b[a] = r_s_d[a] + $signed(mb);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_hit <= r_hit_d;
            r_a   <= n_a;
            r_b   <= n_b;
        end
    end

    assign o_hit = r_hit;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule
`default_nettype wire

@@ hw/rtl/segment_box_clip_top.sv @@
// Top level of the segment box clipper: pipeline control and datapath wiring.
// Depends on sbc_pkg, sbc_front, sbc_div, sbc_delay, sbc_back.
//
// Usage
//   Input channel: i_valid / o_ready with one request per segment query (cube
//   centre, segment start and end in Q15.16, half-size in unsigned Q14.16).
//   Output channel: o_valid / i_ready, one result per request: o_hit and the
//   clipped entry and exit points, zero when the segment misses the cube.
//   Pipeline: two front stages, one restoring-divider stage per quotient
//   bit, then select, multiply and round stages.
//   Throughput: one request per cycle while o_ready is high; six divider lanes work in parallel.
//   Stall: each stage holds while its successor is full and blocked, so
//   bubbles close up and the pipeline keeps accepting until every stage
//   is occupied. Nothing is dropped or repeated.
//   Reset: synchronous, active low; clears all stage valid bits, the
//   datapath registers are not reset.
`default_nettype none
module segment_box_clip_top #(
    parameter int COORD_BITS      = 31,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_box_center_x,
    input  logic signed [COORD_BITS-1:0]  i_box_center_y,
    input  logic signed [COORD_BITS-1:0]  i_box_center_z,
    input  logic [COORD_BITS-2:0]         i_half_size,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_x,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_y,
    input  logic signed [COORD_BITS-1:0]  i_seg_start_z,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_x,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_y,
    input  logic signed [COORD_BITS-1:0]  i_seg_end_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_hit,
    output logic signed [COORD_BITS-1:0]  o_clip_a_x,
    output logic signed [COORD_BITS-1:0]  o_clip_a_y,
    output logic signed [COORD_BITS-1:0]  o_clip_a_z,
    output logic signed [COORD_BITS-1:0]  o_clip_b_x,
    output logic signed [COORD_BITS-1:0]  o_clip_b_y,
    output logic signed [COORD_BITS-1:0]  o_clip_b_z
);
    import sbc_pkg::*;

    localparam int W      = COORD_BITS;
    localparam int F      = PARAM_FRAC_BITS;
    localparam int D      = W + 1;
    localparam int DIV_N  = F + 1;
    localparam int NSTG   = DIV_N + 5;   // front 2, divider, back 3
    localparam int SIDE_W = $bits(t_side);
    localparam int DLY_W  = 3 * W + 3 * D + SIDE_W;

    // Stage valid bits and per-stage advance enables.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTG-1];

    // Front end.
    logic signed [W-1:0] c_in [3];
    logic signed [W-1:0] s_in [3];
    logic signed [W-1:0] e_in [3];
    logic signed [W-1:0] f_s [3];
    logic [D-1:0]        f_num_st [3];
    logic [D-1:0]        f_num_et [3];
    logic [D-1:0]        f_den [3];
    t_side               f_side;

    assign c_in = '{i_box_center_x, i_box_center_y, i_box_center_z};
    assign s_in = '{i_seg_start_x, i_seg_start_y, i_seg_start_z};
    assign e_in = '{i_seg_end_x, i_seg_end_y, i_seg_end_z};

    sbc_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_en     (en[1:0]),
        .i_c      (c_in),
        .i_r      (i_half_size),
        .i_s      (s_in),
        .i_e      (e_in),
        .o_s      (f_s),
        .o_num_st (f_num_st),
        .o_num_et (f_num_et),
        .o_den    (f_den),
        .o_side   (f_side)
    );

    // Six divider lanes: entry and exit parameter on each axis.
    logic [F:0] q_st [3];
    logic [F:0] q_et [3];

    for (genvar a = 0; a < 3; a++) begin : g_div
        sbc_div #(.W(W), .F(F)) u_div_st (
            .i_clk (i_clk),
            .i_en  (en[DIV_N+1:2]),
            .i_num (f_num_st[a]),
            .i_den (f_den[a]),
            .o_q   (q_st[a])
        );
        sbc_div #(.W(W), .F(F)) u_div_et (
            .i_clk (i_clk),
            .i_en  (en[DIV_N+1:2]),
            .i_num (f_num_et[a]),
            .i_den (f_den[a]),
            .o_q   (q_et[a])
        );
    end

    // Start points, magnitudes and flags ride alongside the dividers.
    logic [DLY_W-1:0]    dly_in, dly_out;
    logic signed [W-1:0] b_s [3];
    logic [D-1:0]        b_d [3];
    t_side               b_side;

    always_comb begin
        dly_in = '0;
        for (int a = 0; a < 3; a++) begin
            dly_in[a*W +: W]         = f_s[a];
            dly_in[3*W + a*D +: D]   = f_den[a];
        end
        dly_in[3*W + 3*D +: SIDE_W] = f_side;
    end

    sbc_delay #(.DW(DLY_W), .DEPTH(DIV_N)) u_delay (
        .i_clk  (i_clk),
        .i_en   (en[DIV_N+1:2]),
        .i_data (dly_in),
        .o_data (dly_out)
    );

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            b_s[a] = dly_out[a*W +: W];
            b_d[a] = dly_out[3*W + a*D +: D];
        end
        b_side = dly_out[3*W + 3*D +: SIDE_W];
    end

    // Back end.
    logic signed [W-1:0] out_a [3];
    logic signed [W-1:0] out_b [3];

    sbc_back #(.W(W), .F(F)) u_back (
        .i_clk  (i_clk),
        .i_en   (en[NSTG-1:NSTG-3]),
        .i_q_st (q_st),
        .i_q_et (q_et),
        .i_s    (b_s),
        .i_d    (b_d),
        .i_side (b_side),
        .o_hit  (o_hit),
        .o_a    (out_a),
        .o_b    (out_b)
    );

    assign o_clip_a_x = out_a[0];
    assign o_clip_a_y = out_a[1];
    assign o_clip_a_z = out_a[2];
    assign o_clip_b_x = out_b[0];
    assign o_clip_b_y = out_b[1];
    assign o_clip_b_z = out_b[2];

endmodule
`default_nettype wire

@@ hw/rtl/sbc_checker.sv @@
// Port-level checks for segment_box_clip_top, attached by bind.
// Depends on segment_box_clip_top.
`default_nettype none
module sbc_checker #(
    parameter int W = 31
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic                 o_hit,
    input logic signed [W-1:0]  o_clip_a_x,
    input logic signed [W-1:0]  o_clip_b_z
);
    // Hold a stalled result: valid, o_hit and o_clip_a_x stay stable.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit) && $stable(o_clip_a_x))
        else $error("stalled result changed");

    // Drop every result after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A miss carries zero points, checked on o_clip_a_x and o_clip_b_z.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> (o_clip_a_x == '0) && (o_clip_b_z == '0))
        else $error("miss with nonzero point");

    // Take a request whenever the output stage is empty.
    a_accept_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_valid |-> o_ready)
        else $error("request refused with empty output stage");

endmodule

bind segment_box_clip_top sbc_checker #(.W(COORD_BITS)) u_sbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_hit      (o_hit),
    .o_clip_a_x (o_clip_a_x),
    .o_clip_b_z (o_clip_b_z)
);
`default_nettype wire

@@ bench/tb_segment_box_clip_top.sv @@
// Self-checking testbench of segment_box_clip_top: directed table, then random queries.
// Depends on segment_box_clip_top and its sub-blocks; results checked against a local predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_box_clip_top;

    localparam int CB = 31;
    localparam int FB = 16;
    localparam int LATENCY = FB + 6;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1000;
    localparam longint T_ONE = longint'(1) << FB;
    localparam longint CMAX = (longint'(1) << (CB - 1)) - 1;
    localparam longint CMIN = -(longint'(1) << (CB - 1));
    localparam longint HMAX = (longint'(1) << (CB - 1)) - 1;

    // One segment query and one clip result, at the block's widths.
    typedef struct {
        logic signed [CB-1:0] ctr [3];
        logic [CB-2:0]        half;
        logic signed [CB-1:0] p0 [3];
        logic signed [CB-1:0] p1 [3];
    } t_query;

    typedef struct {
        logic                 hit;
        logic signed [CB-1:0] a [3];
        logic signed [CB-1:0] b [3];
    } t_clip;

    // Directed row: query plus an optional typed-in answer.
    typedef struct {
        t_query q;
        bit     known;
        t_clip  r;
    } t_row;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready, o_hit;
    logic signed [CB-1:0] i_box_center_x, i_box_center_y, i_box_center_z;
    logic [CB-2:0] i_half_size;
    logic signed [CB-1:0] i_seg_start_x, i_seg_start_y, i_seg_start_z;
    logic signed [CB-1:0] i_seg_end_x, i_seg_end_y, i_seg_end_z;
    logic signed [CB-1:0] o_clip_a_x, o_clip_a_y, o_clip_a_z;
    logic signed [CB-1:0] o_clip_b_x, o_clip_b_y, o_clip_b_z;

    segment_box_clip_top #(.COORD_BITS(CB), .PARAM_FRAC_BITS(FB)) dut (.*);

    t_clip  pending_clips [$];
    t_row   directed [$];
    int     n_mismatch, n_checked, n_hits, idle_cycles;
    bit     timed_out;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Parameter in Q1.FB: truncated restoring quotient, saturating at one.
    function automatic longint param_quot(longint num, longint den);
        longint rem, q;
        rem = num;
        q = 0;
        if (den == 0 || num >= den) return T_ONE;
        for (int i = 0; i <= FB; i++) begin
            q = q << 1;
            if (rem >= den) begin
                rem -= den;
                q |= 1;
            end
            rem = rem << 1;
        end
        return q;
    endfunction

    // Point along the segment at t, magnitude rounded half away from zero.
    function automatic logic signed [CB-1:0] point_at(longint s, longint e, longint t);
        longint mag, scaled;
        mag = (e >= s) ? e - s : s - e;
        scaled = (mag >> FB) * t + (((mag & (T_ONE - 1)) * t + (T_ONE >> 1)) >> FB);
        return (e >= s) ? CB'(s + scaled) : CB'(s - scaled);
    endfunction

    function automatic t_clip predict_clip(t_query q);
        t_clip  res;
        longint t_in, t_out, c, s, e, r, hi, lo, st, et;
        t_in = 0;
        t_out = T_ONE;
        res.hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            res.a[i] = '0;
            res.b[i] = '0;
        end
        r = longint'(q.half);
        for (int i = 0; i < 3; i++) begin
            c = q.ctr[i];
            s = q.p0[i];
            e = q.p1[i];
            hi = c + r;
            lo = c - r;
            st = 0;
            et = T_ONE;
            if (s < e) begin
                if (s > hi || e < lo) return res;
                if (lo > s) st = param_quot(lo - s, e - s);
                if (e > hi) et = param_quot(hi - s, e - s);
            end else begin
                // equal ends fall here and never divide
                if (e > hi || s < lo) return res;
                if (hi < s) st = param_quot(s - hi, s - e);
                if (e < lo) et = param_quot(s - lo, s - e);
            end
            if (st > t_in) t_in = st;
            if (et < t_out) t_out = et;
            if (t_out < t_in) return res;
        end
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            res.a[i] = point_at(q.p0[i], q.p1[i], t_in);
            res.b[i] = point_at(q.p0[i], q.p1[i], t_out);
        end
        return res;
    endfunction

    function automatic longint rnd_coord();
        case ($urandom_range(0, 3))
            0: return longint'($urandom_range(0, 32'h7fff_ffff)) + CMIN;
            1: return longint'($urandom_range(0, 40 << 16)) - (20 << 16);
            2: return longint'($urandom_range(0, 2000)) - 1000;
            default: return ($urandom_range(0, 1)) ? CMAX - $urandom_range(0, 3)
                                                  : CMIN + $urandom_range(0, 3);
        endcase
    endfunction

    // Mostly segments near a small cube so that entries, exits and misses all occur.
    function automatic t_query rnd_query();
        t_query q;
        longint c, sp;
        bit     local_q;
        local_q = ($urandom_range(0, 3) != 0);
        q.half = local_q ? (CB-1)'($urandom_range(0, 8 << 16))
                         : (CB-1)'($urandom_range(0, 32'h3fff_ffff));
        if ($urandom_range(0, 15) == 0) q.half = ($urandom_range(0, 1)) ? '0 : (CB-1)'(HMAX);
        for (int i = 0; i < 3; i++) begin
            c = rnd_coord();
            if (local_q && (c > CMAX - (64 << 16) || c < CMIN + (64 << 16))) c = c / 4;
            q.ctr[i] = CB'(c);
            sp = $urandom_range(0, 24 << 16);
            q.p0[i] = local_q ? CB'(c + longint'($urandom_range(0, 2 * sp)) - sp)
                              : CB'(rnd_coord());
            q.p1[i] = ($urandom_range(0, 9) == 0) ? q.p0[i] :
                      local_q ? CB'(c + longint'($urandom_range(0, 2 * sp)) - sp)
                              : CB'(rnd_coord());
        end
        return q;
    endfunction

    function automatic t_query make_query(longint cx, longint cy, longint cz, longint h,
                                          longint sx, longint sy, longint sz,
                                          longint ex, longint ey, longint ez);
        t_query q;
        q.ctr[0] = CB'(cx); q.ctr[1] = CB'(cy); q.ctr[2] = CB'(cz);
        q.half = (CB-1)'(h);
        q.p0[0] = CB'(sx); q.p0[1] = CB'(sy); q.p0[2] = CB'(sz);
        q.p1[0] = CB'(ex); q.p1[1] = CB'(ey); q.p1[2] = CB'(ez);
        return q;
    endfunction

    task automatic add_row(t_query q, bit known, bit hit,
                           longint ax, longint ay, longint az,
                           longint bx, longint by, longint bz);
        t_row row;
        row.q = q;
        row.known = known;
        row.r.hit = hit;
        row.r.a[0] = CB'(ax); row.r.a[1] = CB'(ay); row.r.a[2] = CB'(az);
        row.r.b[0] = CB'(bx); row.r.b[1] = CB'(by); row.r.b[2] = CB'(bz);
        directed.push_back(row);
    endtask

    task automatic build_table();
        longint u;
        u = 1 << 16;
        // segment fully inside: endpoints come back unchanged
        add_row(make_query(0, 0, 0, u, -u/2, -u/2, -u/2, u/2, u/2, u/2),
                1, 1, -u/2, -u/2, -u/2, u/2, u/2, u/2);
        // miss on x: all fields zero
        add_row(make_query(0, 0, 0, u, 3*u, 0, 0, 5*u, 0, 0), 1, 0, 0, 0, 0, 0, 0, 0);
        // straight through along x, ascending and descending
        add_row(make_query(0, 0, 0, u, -2*u, 0, 0, 2*u, 0, 0), 1, 1, -u, 0, 0, u, 0, 0);
        add_row(make_query(0, 0, 0, u, 2*u, 0, 0, -2*u, 0, 0), 1, 1, u, 0, 0, -u, 0, 0);
        // point segment inside, point segment outside
        add_row(make_query(0, 0, 0, u, 5, 6, 7, 5, 6, 7), 1, 1, 5, 6, 7, 5, 6, 7);
        add_row(make_query(0, 0, 0, u, 2*u, 0, 0, 2*u, 0, 0), 1, 0, 0, 0, 0, 0, 0, 0);
        // degenerate point cube, crossing and missing it
        add_row(make_query(0, 0, 0, 0, -u, 0, 0, u, 0, 0), 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(0, 0, 0, 0, -u, 1, 0, u, 1, 0), 1, 0, 0, 0, 0, 0, 0, 0);
        // touching the face and the corner
        add_row(make_query(0, 0, 0, u, u, -2*u, 0, u, 2*u, 0), 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(0, 0, 0, u, 0, 2*u, 0, 2*u, 0, 0), 0, 0, 0, 0, 0, 0, 0, 0);
        // diagonal that misses only after narrowing
        add_row(make_query(0, 0, 0, u, -3*u, 0, 0, 0, 3*u, 0), 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(0, 0, 0, u, -3*u, -u, 2*u, 3*u, u/2, -3*u),
                0, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(7, -9, 3, 3*u, 3, 2*u, -5*u, 11, -2*u, 4*u),
                0, 0, 0, 0, 0, 0, 0, 0);
        // coordinate extremes: segments and cubes at the ends of the coordinate range
        add_row(make_query(0, 0, 0, HMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX),
                1, 1, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        add_row(make_query(CMAX, CMIN, CMAX, HMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX),
                0, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(CMIN, CMAX, 0, 0, CMAX, CMIN, 0, CMIN, CMAX, 0),
                0, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(CMAX, CMAX, CMAX, HMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
                1, 1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        add_row(make_query(CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN),
                0, 0, 0, 0, 0, 0, 0, 0);
        add_row(make_query(-1, 1, -1, 1, 1, -1, 1, -1, 1, -1), 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // Present one request and hold it until accepted.
    task automatic send_query(t_query q);
        i_valid        <= 1'b1;
        i_box_center_x <= q.ctr[0];
        i_box_center_y <= q.ctr[1];
        i_box_center_z <= q.ctr[2];
        i_half_size    <= q.half;
        i_seg_start_x  <= q.p0[0];
        i_seg_start_y  <= q.p0[1];
        i_seg_start_z  <= q.p0[2];
        i_seg_end_x    <= q.p1[0];
        i_seg_end_y    <= q.p1[1];
        i_seg_end_z    <= q.p1[2];
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid for a gap, or keep it high when the next request follows at once.
    task automatic idle_input(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(string field, longint want, longint got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch #%0d on %s: expected %0d, got %0d (result %0d)",
                     n_mismatch, field, want, got, n_checked);
    endtask

    // Check each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_clip want;
        logic signed [CB-1:0] got_a [3];
        logic signed [CB-1:0] got_b [3];
        if (i_rst_n && o_valid && i_ready) begin
            got_a[0] = o_clip_a_x; got_a[1] = o_clip_a_y; got_a[2] = o_clip_a_z;
            got_b[0] = o_clip_b_x; got_b[1] = o_clip_b_y; got_b[2] = o_clip_b_z;
            if (pending_clips.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                want = pending_clips.pop_front();
                if (o_hit !== want.hit) report_mismatch("hit", want.hit, o_hit);
                for (int i = 0; i < 3; i++) begin
                    if (got_a[i] !== want.a[i])
                        report_mismatch($sformatf("clip_a[%0d]", i), want.a[i], got_a[i]);
                    if (got_b[i] !== want.b[i])
                        report_mismatch($sformatf("clip_b[%0d]", i), want.b[i], got_b[i]);
                end
                n_hits += want.hit;
            end
            n_checked++;
        end
    end

    // Predict at acceptance so expectations queue in request order.
    always @(posedge i_clk) begin
        t_query q;
        if (i_rst_n && i_valid && o_ready) begin
            q.ctr[0] = i_box_center_x; q.ctr[1] = i_box_center_y; q.ctr[2] = i_box_center_z;
            q.half = i_half_size;
            q.p0[0] = i_seg_start_x; q.p0[1] = i_seg_start_y; q.p0[2] = i_seg_start_z;
            q.p1[0] = i_seg_end_x; q.p1[1] = i_seg_end_y; q.p1[2] = i_seg_end_z;
            pending_clips.push_back(predict_clip(q));
        end
    end

    // Receiver stalls: alternate ready runs and stall runs; some stall runs are skipped.
    initial begin
        int run;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            run = $urandom_range(1, 12);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if ($urandom_range(0, 4) != 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Watchdog: count cycles with no request or result accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding", pending_clips.size());
            $display("** segment_box_clip_top: FAILED **");
            $finish;
        end
    end

    initial begin
        t_clip cmp;
        int    burst, sent;
        n_mismatch = 0;
        n_checked = 0;
        n_hits = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_box_center_x <= '0; i_box_center_y <= '0; i_box_center_z <= '0;
        i_half_size <= '0;
        i_seg_start_x <= '0; i_seg_start_y <= '0; i_seg_start_z <= '0;
        i_seg_end_x <= '0; i_seg_end_y <= '0; i_seg_end_z <= '0;
        build_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: confirm the typed-in answers agree with the predictor too.
        foreach (directed[k]) begin
            if (directed[k].known) begin
                cmp = predict_clip(directed[k].q);
                if (cmp.hit !== directed[k].r.hit || cmp.a != directed[k].r.a ||
                    cmp.b != directed[k].r.b)
                    report_mismatch($sformatf("directed row %0d answer", k), 1, 0);
            end
            send_query(directed[k].q);
            idle_input($urandom_range(0, 1));
        end

        // Hold off until the pipeline drains once.
        i_valid <= 1'b0;
        while (pending_clips.size() != 0) @(posedge i_clk);

        // Random part in bursts, with long back-to-back runs now and then.
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
            for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
                send_query(rnd_query());
                sent++;
            end
            idle_input($urandom_range(0, 6));
        end
        i_valid <= 1'b0;

        while (pending_clips.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("checked %0d results (%0d hits) from %0d directed and %0d random queries",
                 n_checked, n_hits, directed.size(), N_RANDOM);
        if (n_mismatch == 0 && pending_clips.size() == 0) begin
            $display("** segment_box_clip_top: PASSED **");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("** segment_box_clip_top: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ segment_box_clip_top.f @@
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_front.sv
hw/rtl/sbc_div.sv
hw/rtl/sbc_delay.sv
hw/rtl/sbc_back.sv
hw/rtl/segment_box_clip_top.sv
hw/rtl/sbc_checker.sv
bench/tb_segment_box_clip_top.sv
